FILE: rtl/hsc_pkg.sv
// Shared types and constants for the hysteresis shot counter and rate meter.
package hsc_pkg;

    localparam int MARGIN_W   = 12;
    localparam int TIMER_W    = 16;
    localparam int WSHOT_W    = 16;
    localparam int SCALE_W    = 8;
    localparam int RATE_W     = 24;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_HYST_MARGIN = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WINDOW_MS   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_SCALE  = 8'd3;

    localparam logic [MARGIN_W-1:0] RST_HYST_MARGIN = 12'd200;
    localparam logic [TIMER_W-1:0]  RST_WINDOW_MS   = 16'd1000;
    localparam logic [TIMER_W-1:0]  RST_LONG_PRESS  = 16'd2000;
    localparam logic [SCALE_W-1:0]  RST_RATE_SCALE  = 8'd60;

    typedef struct packed {
        logic [MARGIN_W-1:0] hysteresis_margin;
        logic [TIMER_W-1:0]  window_ms;
        logic [TIMER_W-1:0]  long_press_ms;
        logic [SCALE_W-1:0]  rate_scale;
    } cfg_t;

    typedef enum logic [1:0] {
        BTN_IDLE,
        BTN_PRESS,
        BTN_LONG
    } btn_state_t;

    typedef struct packed {
        logic calib;
        logic rearm;
        logic clear;
    } btn_ctrl_t;

endpackage

FILE: rtl/hsc_cfg_regs.sv
// Configuration register file with write decode.
module hsc_cfg_regs
    import hsc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_HYST_MARGIN: cfg_next.hysteresis_margin = cfg_data[MARGIN_W-1:0];
                REG_WINDOW_MS:   cfg_next.window_ms         = cfg_data[TIMER_W-1:0];
                REG_LONG_PRESS:  cfg_next.long_press_ms     = cfg_data[TIMER_W-1:0];
                REG_RATE_SCALE:  cfg_next.rate_scale        = cfg_data[SCALE_W-1:0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hysteresis_margin <= RST_HYST_MARGIN;
            cfg_reg.window_ms         <= RST_WINDOW_MS;
            cfg_reg.long_press_ms     <= RST_LONG_PRESS;
            cfg_reg.rate_scale        <= RST_RATE_SCALE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

FILE: rtl/hsc_button.sv
// Button press tracker: short press and long press into calibration.
module hsc_button
    import hsc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               step,
    input  logic               button_down,
    input  logic               ms_tick,
    input  logic [TIMER_W-1:0] long_press_ms,
    output btn_ctrl_t          ctrl
);

    btn_state_t         state_reg;
    btn_state_t         state_next;
    logic [TIMER_W-1:0] press_timer_reg;
    logic [TIMER_W-1:0] press_timer_next;
    logic               calib_reg;
    logic               calib_next;
    logic               rearm;
    logic               clear;
    logic [TIMER_W-1:0] press_adv;
    logic               first_long;
    logic               held_long;

    // advance on tick, saturate
    assign press_adv  = (ms_tick && (press_timer_reg != '1)) ? press_timer_reg + 1'b1
                                                             : press_timer_reg;
    assign first_long = (long_press_ms == '0);
    assign held_long  = (press_adv >= long_press_ms);

    always_comb
    begin
        state_next       = state_reg;
        press_timer_next = press_timer_reg;
        unique case (state_reg)
            BTN_IDLE:
            begin
                if (button_down)
                begin
                    press_timer_next = '0;
                    state_next       = first_long ? BTN_LONG : BTN_PRESS;
                end
            end
            BTN_PRESS:
            begin
                if (button_down)
                begin
                    press_timer_next = press_adv;
                    if (held_long)
                        state_next = BTN_LONG;
                end
                else
                begin
                    state_next = BTN_IDLE;
                end
            end
            BTN_LONG:
            begin
                if (!button_down)
                    state_next = BTN_IDLE;
            end
            default:
            begin
                state_next = BTN_IDLE;
            end
        endcase
    end

    always_comb
    begin
        calib_next = calib_reg;
        rearm      = 1'b0;
        clear      = 1'b0;
        unique case (state_reg)
            BTN_IDLE:
            begin
                if (button_down && first_long)
                    calib_next = 1'b1;
            end
            BTN_PRESS:
            begin
                if (button_down)
                begin
                    if (held_long)
                        calib_next = 1'b1;
                end
                else if (calib_reg)
                begin
                    // short press leaves calibration
                    calib_next = 1'b0;
                    rearm      = 1'b1;
                end
                else
                begin
                    clear = 1'b1;
                end
            end
            BTN_LONG:
            begin
                calib_next = calib_reg;
            end
            default:
            begin
                calib_next = calib_reg;
            end
        endcase
    end

    assign ctrl.calib = calib_next;
    assign ctrl.rearm = rearm;
    assign ctrl.clear = clear;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= BTN_IDLE;
            press_timer_reg <= '0;
            calib_reg       <= 1'b0;
        end
        else if (step)
        begin
            state_reg       <= state_next;
            press_timer_reg <= press_timer_next;
            calib_reg       <= calib_next;
        end
    end

endmodule

FILE: rtl/hsc_meter.sv
// Schmitt detector, shot counters, window timer and rate computation.
module hsc_meter
    import hsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int TOTAL_BITS  = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   step,
    input  logic [SAMPLE_BITS-1:0] sensor_sample,
    input  logic [SAMPLE_BITS-1:0] threshold,
    input  logic                   ms_tick,
    input  cfg_t                   cfg,
    input  btn_ctrl_t              ctrl,
    output logic                   shot,
    output logic [TOTAL_BITS-1:0]  total,
    output logic [RATE_W-1:0]      rate,
    output logic                   rate_upd
);

    localparam int SUM_W = ((SAMPLE_BITS > MARGIN_W) ? SAMPLE_BITS : MARGIN_W) + 1;

    logic                  armed_reg;
    logic                  armed_next;
    logic [WSHOT_W-1:0]    wshots_reg;
    logic [WSHOT_W-1:0]    wshots_next;
    logic [TOTAL_BITS-1:0] total_reg;
    logic [TOTAL_BITS-1:0] total_next;
    logic [RATE_W-1:0]     rate_reg;
    logic [RATE_W-1:0]     rate_next;
    logic [TIMER_W-1:0]    wtimer_reg;
    logic [TIMER_W-1:0]    wtimer_next;

    logic [TIMER_W-1:0]    wtimer_adv;
    logic                  armed_cur;
    logic [WSHOT_W-1:0]    wshots_base;
    logic [TOTAL_BITS-1:0] total_base;
    logic [RATE_W-1:0]     rate_base;
    logic [SUM_W-1:0]      rearm_level;
    logic                  below;
    logic                  above;
    logic [WSHOT_W-1:0]    wshots_inc;
    logic                  window_end;
    logic [RATE_W-1:0]     product;

    assign wtimer_adv  = (ms_tick && (wtimer_reg != '1)) ? wtimer_reg + 1'b1 : wtimer_reg;
    assign armed_cur   = armed_reg | ctrl.rearm;
    assign wshots_base = ctrl.clear ? '0 : wshots_reg;
    assign total_base  = ctrl.clear ? '0 : total_reg;
    assign rate_base   = ctrl.clear ? '0 : rate_reg;

    assign rearm_level = SUM_W'(threshold) + SUM_W'(cfg.hysteresis_margin);
    assign below       = (sensor_sample < threshold);
    assign above       = (SUM_W'(sensor_sample) > rearm_level);

    assign shot       = !ctrl.calib && armed_cur && below;
    assign wshots_inc = (shot && (wshots_base != '1)) ? wshots_base + 1'b1 : wshots_base;
    assign window_end = !ctrl.calib && (wtimer_adv >= cfg.window_ms);
    assign product    = RATE_W'(wshots_inc) * RATE_W'(cfg.rate_scale);

    always_comb
    begin
        armed_next  = armed_cur;
        total_next  = total_base + TOTAL_BITS'(shot);
        wshots_next = wshots_inc;
        rate_next   = rate_base;
        wtimer_next = wtimer_adv;
        if (shot)
            armed_next = 1'b0;
        else if (!ctrl.calib && above)
            armed_next = 1'b1;
        if (window_end)
        begin
            rate_next   = product;
            wshots_next = '0;
            wtimer_next = '0;
        end
    end

    assign total    = total_next;
    assign rate     = rate_next;
    assign rate_upd = window_end;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg  <= 1'b1;
            wshots_reg <= '0;
            total_reg  <= '0;
            rate_reg   <= '0;
            wtimer_reg <= '0;
        end
        else if (step)
        begin
            armed_reg  <= armed_next;
            wshots_reg <= wshots_next;
            total_reg  <= total_next;
            rate_reg   <= rate_next;
            wtimer_reg <= wtimer_next;
        end
    end

endmodule

FILE: rtl/hysteresis_shot_counter_rate_meter_core.sv
// Shot counter with hysteresis detector and windowed rate meter: top level.
// From input acceptance to result valid, a word passes the input register, then the result register.
// Throughput: one word per cycle while results drain; out_ready low stalls the input register.
// A finished result may wait in the output register while the next word is taken.
// Reset: configuration returns to defaults, counters and timers clear, detector is armed.
module hysteresis_shot_counter_rate_meter_core
    import hsc_pkg::*;
#(
    parameter int SAMPLE_BITS = 12,
    parameter int TOTAL_BITS  = 32
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [SAMPLE_BITS-1:0] sensor_sample,
    input  logic [SAMPLE_BITS-1:0] threshold,
    input  logic                   button_down,
    input  logic                   ms_tick,
    output logic                   out_valid,
    input  logic                   out_ready,
    output logic                   shot_pulse,
    output logic [TOTAL_BITS-1:0]  total_shots,
    output logic [RATE_W-1:0]      rate_per_period,
    output logic                   rate_updated,
    output logic                   calibrating,
    output logic                   counts_cleared
);

    cfg_t                   cfg;
    btn_ctrl_t              ctrl;

    logic                   in_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic [SAMPLE_BITS-1:0] thresh_reg;
    logic                   button_reg;
    logic                   tick_reg;

    logic                   out_valid_reg;
    logic                   shot_reg;
    logic [TOTAL_BITS-1:0]  total_reg;
    logic [RATE_W-1:0]      rate_reg;
    logic                   rate_upd_reg;
    logic                   calib_reg;
    logic                   cleared_reg;

    logic                   step;
    logic                   accept;
    logic                   shot;
    logic [TOTAL_BITS-1:0]  total;
    logic [RATE_W-1:0]      rate;
    logic                   rate_upd;

    // move the held word into the result register when that slot frees up
    assign step     = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || step;
    assign accept   = in_valid && in_ready;

    hsc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hsc_button u_button (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .button_down   (button_reg),
        .ms_tick       (tick_reg),
        .long_press_ms (cfg.long_press_ms),
        .ctrl          (ctrl)
    );

    hsc_meter #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TOTAL_BITS  (TOTAL_BITS)
    ) u_meter (
        .clk           (clk),
        .rst_n         (rst_n),
        .step          (step),
        .sensor_sample (sample_reg),
        .threshold     (thresh_reg),
        .ms_tick       (tick_reg),
        .cfg           (cfg),
        .ctrl          (ctrl),
        .shot          (shot),
        .total         (total),
        .rate          (rate),
        .rate_upd      (rate_upd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
                in_valid_reg <= 1'b1;
            else if (step)
                in_valid_reg <= 1'b0;

            if (step)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            sample_reg <= sensor_sample;
            thresh_reg <= threshold;
            button_reg <= button_down;
            tick_reg   <= ms_tick;
        end
        if (step)
        begin
            shot_reg     <= shot;
            total_reg    <= total;
            rate_reg     <= rate;
            rate_upd_reg <= rate_upd;
            calib_reg    <= ctrl.calib;
            cleared_reg  <= ctrl.clear;
        end
    end

    assign out_valid       = out_valid_reg;
    assign shot_pulse      = shot_reg;
    assign total_shots     = total_reg;
    assign rate_per_period = rate_reg;
    assign rate_updated    = rate_upd_reg;
    assign calibrating     = calib_reg;
    assign counts_cleared  = cleared_reg;

endmodule

FILE: test/hysteresis_shot_counter_rate_meter_core_tb.sv
// Self-checking testbench for the hysteresis shot counter and rate meter core.
`timescale 1ns / 100ps

module hysteresis_shot_counter_rate_meter_core_tb;
    import hsc_pkg::*;

    localparam int SAMPLE_W     = 12;
    localparam int TOTAL_W      = 32;
    localparam int QUIET_LIMIT  = 1000;
    localparam int HOLD_CYCLES  = 80;
    localparam int SETTLE_CYCLES = 20;

    typedef struct packed {
        logic [SAMPLE_W-1:0] reading;
        logic [SAMPLE_W-1:0] thresh;
        logic                button;
        logic                tick;
    } sample_word_t;

    typedef struct packed {
        logic               shot;
        logic [TOTAL_W-1:0] total;
        logic [RATE_W-1:0]  rate;
        logic               rate_upd;
        logic               calib;
        logic               cleared;
    } shot_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;
    logic                  in_valid = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   sensor_sample = '0;
    logic [SAMPLE_W-1:0]   threshold = '0;
    logic                  button_down = 1'b0;
    logic                  ms_tick = 1'b0;
    logic                  out_valid;
    logic                  out_ready = 1'b0;
    logic                  shot_pulse;
    logic [TOTAL_W-1:0]    total_shots;
    logic [RATE_W-1:0]     rate_per_period;
    logic                  rate_updated;
    logic                  calibrating;
    logic                  counts_cleared;

    hysteresis_shot_counter_rate_meter_core DUT (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .sensor_sample   (sensor_sample),
        .threshold       (threshold),
        .button_down     (button_down),
        .ms_tick         (ms_tick),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .shot_pulse      (shot_pulse),
        .total_shots     (total_shots),
        .rate_per_period (rate_per_period),
        .rate_updated    (rate_updated),
        .calibrating     (calibrating),
        .counts_cleared  (counts_cleared)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    sample_word_t sample_backlog[$];
    shot_result_t meter_expect[$];

    int  words_queued = 0;
    int  words_taken  = 0;
    int  cfg_writes   = 0;
    int  mismatches   = 0;
    int  quiet_cycles = 0;
    int  hold_reqs    = 0;
    int  hold_done    = 0;
    int  hold_left    = 0;
    bit  steady       = 1'b0;
    logic word_taken  = 1'b0;

    // Register values as last programmed, used to shape stimulus
    logic [MARGIN_W-1:0] cur_margin = RST_HYST_MARGIN;
    logic [TIMER_W-1:0]  cur_long   = RST_LONG_PRESS;

    // Predictor copy of the registers and the meter state
    logic [MARGIN_W-1:0] p_margin = RST_HYST_MARGIN;
    logic [TIMER_W-1:0]  p_window = RST_WINDOW_MS;
    logic [TIMER_W-1:0]  p_long   = RST_LONG_PRESS;
    logic [SCALE_W-1:0]  p_scale  = RST_RATE_SCALE;
    logic                p_armed  = 1'b1;
    logic [WSHOT_W-1:0]  p_wshots = '0;
    logic [TOTAL_W-1:0]  p_total  = '0;
    logic [RATE_W-1:0]   p_rate   = '0;
    logic [TIMER_W-1:0]  p_wtimer = '0;
    logic                p_calib  = 1'b0;
    logic                p_held   = 1'b0;
    logic                p_long_seen = 1'b0;
    logic [TIMER_W-1:0]  p_ptimer = '0;

    function automatic void advance_meter(input sample_word_t w);
        shot_result_t r;
        logic [SAMPLE_W:0] rearm_level;
        r = '0;
        if (w.tick && p_wtimer != '1)
            p_wtimer++;

        if (w.button && !p_held)
        begin
            p_held      = 1'b1;
            p_ptimer    = '0;
            p_long_seen = 1'b0;
        end
        else if (w.button && p_held && !p_long_seen)
        begin
            if (w.tick && p_ptimer != '1)
                p_ptimer++;
        end
        if (w.button && p_held && !p_long_seen && p_ptimer >= p_long)
        begin
            p_long_seen = 1'b1;
            p_calib     = 1'b1;
        end
        if (!w.button && p_held)
        begin
            if (!p_long_seen)
            begin
                if (p_calib)
                begin
                    p_calib = 1'b0;
                    p_armed = 1'b1;
                end
                else
                begin
                    p_wshots  = '0;
                    p_total   = '0;
                    p_rate    = '0;
                    r.cleared = 1'b1;
                end
            end
            p_held = 1'b0;
        end

        if (!p_calib)
        begin
            rearm_level = {1'b0, w.thresh} + {1'b0, p_margin};
            if (p_armed && w.reading < w.thresh)
            begin
                r.shot  = 1'b1;
                p_armed = 1'b0;
                if (p_wshots != '1)
                    p_wshots++;
                p_total++;
            end
            else if ({1'b0, w.reading} > rearm_level)
            begin
                p_armed = 1'b1;
            end
            // close the window: rate from the saturated count
            if (p_wtimer >= p_window)
            begin
                p_rate     = RATE_W'(p_wshots) * RATE_W'(p_scale);
                p_wshots   = '0;
                p_wtimer   = '0;
                r.rate_upd = 1'b1;
            end
        end

        r.total = p_total;
        r.rate  = p_rate;
        r.calib = p_calib;
        meter_expect.push_back(r);
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
        end
    endfunction

    // Monitor: predict on accepted words, check accepted results, watch for hangs
    always @(posedge clk)
    begin
        shot_result_t want;
        bit           moved;
        moved = 1'b0;
        word_taken <= in_valid && in_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                moved = 1'b1;
                cfg_writes++;
                case (cfg_index)
                    REG_HYST_MARGIN: p_margin = cfg_data[MARGIN_W-1:0];
                    REG_WINDOW_MS:   p_window = cfg_data[TIMER_W-1:0];
                    REG_LONG_PRESS:  p_long   = cfg_data[TIMER_W-1:0];
                    REG_RATE_SCALE:  p_scale  = cfg_data[SCALE_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                moved = 1'b1;
                words_taken++;
                advance_meter('{sensor_sample, threshold, button_down, ms_tick});
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (meter_expect.size() == 0)
                begin
                    mismatches++;
                    $display("%0t ns: result with no word pending", $time);
                end
                else
                begin
                    want = meter_expect.pop_front();
                    check_field("shot_pulse", 32'(want.shot), 32'(shot_pulse));
                    check_field("total_shots", want.total, total_shots);
                    check_field("rate_per_period", 32'(want.rate), 32'(rate_per_period));
                    check_field("rate_updated", 32'(want.rate_upd), 32'(rate_updated));
                    check_field("calibrating", 32'(want.calib), 32'(calibrating));
                    check_field("counts_cleared", 32'(want.cleared), 32'(counts_cleared));
                end
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t ns: no handshake for %0d cycles", $time, QUIET_LIMIT);
                $display("[hysteresis_shot_counter_rate_meter_core] ERROR");
                $finish;
            end
        end
    end

    // Sample driver: hold the word until taken, then offer the next or idle
    always @(negedge clk)
    begin
        sample_word_t w;
        if (rst_n && (!in_valid || word_taken))
        begin
            if (sample_backlog.size() != 0 && (steady || $urandom_range(99) >= 34))
            begin
                w = sample_backlog.pop_front();
                in_valid      <= 1'b1;
                sensor_sample <= w.reading;
                threshold     <= w.thresh;
                button_down   <= w.button;
                ms_tick       <= w.tick;
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    // Result acceptor with random stalls and requested long hold-offs
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else if (hold_reqs != hold_done)
        begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= steady || $urandom_range(99) >= 34;
        end
    end

    task automatic send_word(input int reading, input int thresh,
                             input logic button, input logic tick);
        sample_backlog.push_back('{SAMPLE_W'(reading), SAMPLE_W'(thresh), button, tick});
        words_queued++;
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (words_taken != words_queued || meter_expect.size() != 0);
    endtask

    // Enter at a falling edge with the block idle
    task automatic set_config(input int margin, input int win, input int lp, input int scale);
        logic [CFG_IDX_W-1:0]  idx [4];
        logic [CFG_DATA_W-1:0] val [4];
        int target;
        idx[0] = REG_HYST_MARGIN;  val[0] = CFG_DATA_W'(margin);
        idx[1] = REG_WINDOW_MS;    val[1] = CFG_DATA_W'(win);
        idx[2] = REG_LONG_PRESS;   val[2] = CFG_DATA_W'(lp);
        idx[3] = REG_RATE_SCALE;   val[3] = CFG_DATA_W'(scale);
        cur_margin = MARGIN_W'(margin);
        cur_long   = TIMER_W'(lp);
        for (int i = 0; i < 4; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx[i];
            cfg_data  <= val[i];
            target = cfg_writes + 1;
            do
                @(negedge clk);
            while (cfg_writes != target);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic logic tick_bit();
        return $urandom_range(2) == 0;
    endfunction

    // Mostly dip/re-arm cycles and button presses around the current registers
    task automatic random_burst(input int count);
        int made, kind, reps, lvl, top, lp, thr;
        made = 0;
        while (made < count)
        begin
            kind = $urandom_range(99);
            if (kind < 50)
            begin
                if (cur_margin <= 4093)
                    thr = $urandom_range(1, 4094 - int'(cur_margin));
                else
                    thr = $urandom_range(1, 4095);
                lvl = thr + int'(cur_margin);
                top = (lvl > 4095) ? 4095 : lvl;
                reps = $urandom_range(0, 2);
                repeat (reps)
                begin
                    if (lvl < 4095)
                        send_word($urandom_range(lvl + 1, 4095), thr, 1'b0, tick_bit());
                    else
                        send_word($urandom_range(0, 4095), thr, 1'b0, tick_bit());
                end
                send_word($urandom_range(0, thr - 1), thr, 1'b0, tick_bit());
                made += reps + 1;
                reps = $urandom_range(0, 3);
                repeat (reps)
                    send_word($urandom_range(thr, top), thr, 1'b0, tick_bit());
                made += reps;
                if (lvl < 4095)
                begin
                    send_word($urandom_range(lvl + 1, 4095), thr, 1'b0, tick_bit());
                    made++;
                end
            end
            else if (kind < 70)
            begin
                // press of random length, around the long-press time when that is short, then release
                lp = int'(cur_long);
                reps = $urandom_range(1, (lp > 18) ? 40 : 2 * lp + 3);
                repeat (reps)
                    send_word($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b1,
                              $urandom_range(9) < 6);
                send_word($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, tick_bit());
                made += reps + 1;
            end
            else if (kind < 85)
            begin
                reps = $urandom_range(1, 6);
                repeat (reps)
                    send_word($urandom_range(0, 4095), $urandom_range(0, 4095), 1'b0, 1'b1);
                made += reps;
            end
            else
            begin
                send_word($urandom_range(0, 4095), $urandom_range(0, 4095),
                          1'($urandom_range(1)), 1'($urandom_range(1)));
                made++;
            end
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Default registers: field extremes, margin boundary, clearing press
        send_word(0, 4095, 1'b0, 1'b0);
        send_word(4095, 0, 1'b0, 1'b1);
        send_word(1234, 1234, 1'b0, 1'b0);
        send_word(1233, 1234, 1'b0, 1'b0);
        send_word(1434, 1234, 1'b0, 1'b0);
        send_word(1000, 1234, 1'b0, 1'b0);
        send_word(1435, 1234, 1'b0, 1'b0);
        send_word(0, 0, 1'b0, 1'b0);
        send_word(4095, 4095, 1'b1, 1'b0);
        send_word(4095, 4095, 1'b0, 1'b0);
        wait_drained();

        // Short windows and presses: calibration entry, hold, exit with late window
        set_config(0, 2, 2, 255);
        send_word(0, 4095, 1'b0, 1'b1);
        send_word(4095, 0, 1'b0, 1'b1);
        send_word(2048, 2048, 1'b1, 1'b1);
        send_word(2048, 2048, 1'b1, 1'b1);
        send_word(2048, 2048, 1'b1, 1'b1);
        send_word(0, 4095, 1'b1, 1'b1);
        send_word(0, 4095, 1'b0, 1'b1);
        send_word(2048, 2048, 1'b0, 1'b1);
        send_word(2048, 2048, 1'b1, 1'b0);
        send_word(2048, 2048, 1'b1, 1'b1);
        send_word(2048, 2048, 1'b1, 1'b1);
        send_word(2048, 2048, 1'b0, 1'b0);
        send_word(2048, 2048, 1'b1, 1'b0);
        send_word(0, 4095, 1'b0, 1'b0);
        send_word(4095, 0, 1'b1, 1'b0);
        send_word(4095, 0, 1'b0, 1'b0);
        wait_drained();

        set_config(0, 1, 1, 255);
        random_burst(140);
        wait_drained();

        set_config(4095, 5, 3, 1);
        random_burst(120);
        @(posedge clk);
        hold_reqs++;
        wait_drained();

        // No idling here; the hold-off backs the core up into its input
        steady = 1'b1;
        set_config($urandom_range(0, 600), $urandom_range(1, 30), $urandom_range(1, 12),
                   $urandom_range(1, 255));
        random_burst(150);
        @(posedge clk);
        hold_reqs++;
        wait_drained();
        steady = 1'b0;

        set_config($urandom_range(0, 600), $urandom_range(1, 30), $urandom_range(1, 12),
                   $urandom_range(1, 255));
        random_burst(150);
        wait_drained();

        set_config($urandom_range(0, 4095), 65535, 65535, $urandom_range(1, 255));
        random_burst(100);
        wait_drained();

        set_config($urandom_range(0, 300), $urandom_range(1, 8), $urandom_range(1, 6),
                   $urandom_range(1, 255));
        random_burst(150);
        wait_drained();

        repeat (SETTLE_CYCLES) @(negedge clk);
        if (meter_expect.size() != 0)
        begin
            mismatches++;
            $display("%0t ns: %0d results never arrived", $time, meter_expect.size());
        end
        if (mismatches == 0)
            $display("[hysteresis_shot_counter_rate_meter_core] OK");
        else
            $display("[hysteresis_shot_counter_rate_meter_core] ERROR");
        $finish;
    end

endmodule

FILE: files.f
rtl/hsc_pkg.sv
rtl/hsc_cfg_regs.sv
rtl/hsc_button.sv
rtl/hsc_meter.sv
rtl/hysteresis_shot_counter_rate_meter_core.sv
test/hysteresis_shot_counter_rate_meter_core_tb.sv
